// ===== src/oaht_pkg.sv =====
package oaht_pkg;

    localparam int SLOTS_DEF = 256;

    localparam int TYPE_W = 2;
    localparam int KEY_W  = 32;
    localparam int HASH_W = 32;
    localparam int VAL_W  = 64;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 9;

    localparam logic [CFG_W-1:0] CFG_MAX_RST = 9'd192;

    localparam logic [TYPE_W-1:0] REQ_SET = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_GET = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_DEL = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_LIVE  = 2'd1;
    localparam logic [1:0] KIND_TOMB  = 2'd2;

endpackage

// ===== src/oaht_req_if.sv =====
interface oaht_req_if;
    logic                        valid;
    logic                        ready;
    logic [oaht_pkg::TYPE_W-1:0] req_type;
    logic [oaht_pkg::KEY_W-1:0]  key_id;
    logic [oaht_pkg::HASH_W-1:0] key_hash;
    logic [oaht_pkg::VAL_W-1:0]  new_value;

    modport source (output valid, req_type, key_id, key_hash, new_value, input ready);
    modport sink   (input valid, req_type, key_id, key_hash, new_value, output ready);
endinterface

// ===== src/oaht_rsp_if.sv =====
interface oaht_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [oaht_pkg::STAT_W-1:0] status;
    logic                        was_new_key;
    logic [oaht_pkg::VAL_W-1:0]  value_out;

    modport source (output valid, status, was_new_key, value_out, input ready);
    modport sink   (input valid, status, was_new_key, value_out, output ready);
endinterface

// ===== src/open_addressing_hash_table.sv =====
// Key/value map with linear probing and tombstones over SLOTS entries, held in three
// single-port-style memories (slot kind, key, value) with a registered read.
// After reset the slot-kind memory is swept to empty, one slot a cycle, so no request
// is taken until the sweep is done; configuration writes are taken at any time.
// A request reduces the hash modulo SLOTS with a reciprocal multiply (registered as the
// request is taken), a remainder step and one correction, then the probe visits 1 to
// SLOTS slots, one per cycle, bounded by the memory read latency. A result waits in an
// output register while the next request is taken; a probe that has finished holds until
// that register is free.
module open_addressing_hash_table #(
    parameter int SLOTS = oaht_pkg::SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    oaht_req_if.sink                   i_req,
    oaht_rsp_if.source                 o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [oaht_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(SLOTS);
    localparam int IW = AW + 1;
    localparam logic [63:0] RECIP_W = (64'd1 << 32) / 64'(SLOTS);
    localparam logic [31:0] RECIP = RECIP_W[31:0];
    localparam logic [IW-1:0] SLOTS_V = IW'(SLOTS);
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_REM   = 5'b00100,
        S_FIX   = 5'b01000,
        S_PROBE = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        PR_MATCH,
        PR_TOMB,
        PR_EMPTY,
        PR_NONE
    } t_probe;

    t_state r_state, n_state;

    logic [1:0]                 r_mem_kind [SLOTS];
    logic [oaht_pkg::KEY_W-1:0] r_mem_key  [SLOTS];
    logic [oaht_pkg::VAL_W-1:0] r_mem_val  [SLOTS];

    logic [1:0]                 r_rd_kind;
    logic [oaht_pkg::KEY_W-1:0] r_rd_key;
    logic [oaht_pkg::VAL_W-1:0] r_rd_val;

    logic [oaht_pkg::TYPE_W-1:0] r_type;
    logic [oaht_pkg::KEY_W-1:0]  r_key;
    logic [oaht_pkg::VAL_W-1:0]  r_newval;
    logic [IW-1:0]               r_hash_lo;
    logic [IW-1:0]               r_quot;
    logic [IW-1:0]               r_rem;

    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_steps;
    logic [AW-1:0] r_tomb;
    logic          r_have_tomb;
    logic [AW-1:0] r_clr;

    logic [oaht_pkg::CFG_W-1:0] r_count;
    logic [oaht_pkg::CFG_W-1:0] r_max;

    logic                        r_out_valid;
    logic [oaht_pkg::STAT_W-1:0] r_status;
    logic                        r_new;
    logic [oaht_pkg::VAL_W-1:0]  r_value;

    logic [63:0]   w_prod;
    logic [IW-1:0] w_qs;
    logic [IW-1:0] w_rem;
    logic [AW-1:0] w_home;
    logic [AW-1:0] w_next_idx;
    logic          w_accept;
    logic          w_out_free;
    logic          w_hit;
    logic          w_is_tomb;
    logic          w_last;
    logic          w_tomb_any;
    logic [AW-1:0] w_tomb_at;
    t_probe        w_probe;
    logic          w_done;
    logic [AW-1:0] w_at;
    logic          w_fire;
    logic          w_room;

    logic                        w_kind_we;
    logic [1:0]                  w_kind_data;
    logic [AW-1:0]               w_kind_addr;
    logic                        w_key_we;
    logic                        w_val_we;
    logic                        w_count_inc;
    logic [oaht_pkg::STAT_W-1:0] w_status;
    logic                        w_new;
    logic [oaht_pkg::VAL_W-1:0]  w_value;

    assign o_cfg_ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.was_new_key = r_new;
    assign o_rsp.value_out   = r_value;

    assign w_out_free = !r_out_valid || o_rsp.ready;

    // hash modulo SLOTS: quotient estimate is low by at most one
    assign w_prod = 64'(i_req.key_hash) * 64'(RECIP);
    assign w_qs   = r_quot * SLOTS_V;
    assign w_rem  = r_hash_lo - w_qs;
    assign w_home = (r_rem >= SLOTS_V) ? AW'(r_rem - SLOTS_V) : AW'(r_rem);

    assign w_next_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;

    assign w_hit      = (r_rd_kind == oaht_pkg::KIND_LIVE) && (r_rd_key == r_key);
    assign w_is_tomb  = (r_rd_kind == oaht_pkg::KIND_TOMB);
    assign w_last     = (r_steps == LAST_IDX);
    assign w_tomb_any = r_have_tomb || w_is_tomb;
    assign w_tomb_at  = r_have_tomb ? r_tomb : r_idx;

    always_comb begin
        w_probe = PR_NONE;
        w_done  = 1'b0;
        w_at    = r_idx;
        if (w_hit) begin
            w_probe = PR_MATCH;
            w_done  = 1'b1;
        end else if (r_rd_kind == oaht_pkg::KIND_LIVE || w_is_tomb) begin
            if (w_last) begin
                w_done = 1'b1;
                if (w_tomb_any) begin
                    w_probe = PR_TOMB;
                    w_at    = w_tomb_at;
                end
            end
        end else begin
            w_done = 1'b1;
            if (r_have_tomb) begin
                w_probe = PR_TOMB;
                w_at    = r_tomb;
            end else begin
                w_probe = PR_EMPTY;
            end
        end
    end

    assign w_fire = (r_state == S_PROBE) && w_done && w_out_free;
    assign w_room = ({1'b0, r_count} + 10'd1) <= {1'b0, r_max};

    always_comb begin
        w_kind_we   = 1'b0;
        w_kind_data = oaht_pkg::KIND_EMPTY;
        w_kind_addr = w_at;
        w_key_we    = 1'b0;
        w_val_we    = 1'b0;
        w_count_inc = 1'b0;
        w_status    = oaht_pkg::ST_NOT_FOUND;
        w_new       = 1'b0;
        w_value     = '0;
        if (r_state == S_CLEAR) begin
            w_kind_we   = 1'b1;
            w_kind_addr = r_clr;
        end else if (w_fire) begin
            unique case (r_type)
                oaht_pkg::REQ_SET: begin
                    if (w_probe == PR_MATCH) begin
                        w_val_we = 1'b1;
                        w_status = oaht_pkg::ST_OK;
                    end else if (w_probe == PR_TOMB || (w_probe == PR_EMPTY && w_room)) begin
                        w_kind_we   = 1'b1;
                        w_kind_data = oaht_pkg::KIND_LIVE;
                        w_key_we    = 1'b1;
                        w_val_we    = 1'b1;
                        w_count_inc = (w_probe == PR_EMPTY);
                        w_status    = oaht_pkg::ST_OK;
                        w_new       = 1'b1;
                    end else begin
                        w_status = oaht_pkg::ST_FULL;
                    end
                end
                oaht_pkg::REQ_GET: begin
                    if (w_probe == PR_MATCH) begin
                        w_status = oaht_pkg::ST_OK;
                        w_value  = r_rd_val;
                    end
                end
                oaht_pkg::REQ_DEL: begin
                    if (w_probe == PR_MATCH) begin
                        w_kind_we   = 1'b1;
                        w_kind_data = oaht_pkg::KIND_TOMB;
                        w_status    = oaht_pkg::ST_OK;
                    end
                end
                default: begin
                    w_status = oaht_pkg::ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_REM;
                end
            end
            S_REM: begin
                n_state = S_FIX;
            end
            S_FIX: begin
                n_idx   = w_home;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (w_done) begin
                    if (w_out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_idx = w_next_idx;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_kind_we) begin
            r_mem_kind[w_kind_addr] <= w_kind_data;
        end
        if (w_key_we) begin
            r_mem_key[w_at] <= r_key;
        end
        if (w_val_we) begin
            r_mem_val[w_at] <= r_newval;
        end
        r_rd_kind <= r_mem_kind[n_idx];
        r_rd_key  <= r_mem_key[n_idx];
        r_rd_val  <= r_mem_val[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_max       <= oaht_pkg::CFG_MAX_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
            if (w_count_inc) begin
                r_count <= r_count + 1'b1;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (w_accept) begin
            r_type    <= i_req.req_type;
            r_key     <= i_req.key_id;
            r_newval  <= i_req.new_value;
            r_hash_lo <= i_req.key_hash[IW-1:0];
            r_quot    <= w_prod[32+IW-1:32];
        end
        if (r_state == S_REM) begin
            r_rem <= w_rem;
        end
        if (r_state == S_FIX) begin
            r_steps     <= '0;
            r_have_tomb <= 1'b0;
        end else if (r_state == S_PROBE && !w_done) begin
            r_steps <= r_steps + 1'b1;
            if (w_is_tomb && !r_have_tomb) begin
                r_have_tomb <= 1'b1;
                r_tomb      <= r_idx;
            end
        end
        if (w_fire) begin
            r_status <= w_status;
            r_new    <= w_new;
            r_value  <= w_value;
        end
    end

    a_out_from_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_PROBE))
        else $error("result loaded outside a probe");

    a_probe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && !w_done) |=>
            (r_state == S_PROBE && r_steps == AW'($past(r_steps) + 1'b1)))
        else $error("probe did not advance one slot");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && w_done && !w_out_free) |=>
            (r_state == S_PROBE && $stable(r_idx) && !$past(w_kind_we)))
        else $error("finished probe moved or wrote while output busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (32'(r_count) <= SLOTS))
        else $error("entry count exceeds table size");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    localparam int NSLOT          = oaht_pkg::SLOTS_DEF;
    localparam int POOL_N         = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 300;

    localparam logic [oaht_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [oaht_pkg::TYPE_W-1:0] req_type;
        logic [oaht_pkg::KEY_W-1:0]  key_id;
        logic [oaht_pkg::HASH_W-1:0] key_hash;
        logic [oaht_pkg::VAL_W-1:0]  new_value;
    } t_map_req;

    typedef struct packed {
        logic [oaht_pkg::STAT_W-1:0] status;
        logic                        was_new_key;
        logic [oaht_pkg::VAL_W-1:0]  value_out;
    } t_map_rsp;

    typedef enum logic [1:0] {
        PROBE_HIT,
        PROBE_TOMB,
        PROBE_EMPTY,
        PROBE_NONE
    } t_probe_res;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [oaht_pkg::CFG_W-1:0] cfg_data;

    oaht_req_if req_if ();
    oaht_rsp_if rsp_if ();

    open_addressing_hash_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // predicted table contents
    logic [1:0]                 tbl_kind [NSLOT];
    logic [oaht_pkg::KEY_W-1:0] tbl_key  [NSLOT];
    logic [oaht_pkg::VAL_W-1:0] tbl_val  [NSLOT];
    logic [oaht_pkg::CFG_W-1:0] tbl_count;
    logic [oaht_pkg::CFG_W-1:0] tbl_limit;

    t_map_req pending_reqs [$];
    t_map_rsp expected_rsps [$];
    t_map_req cur_req;
    t_map_rsp got_rsp;
    t_map_rsp want_rsp;

    logic [oaht_pkg::KEY_W-1:0]  pool_key  [POOL_N];
    logic [oaht_pkg::HASH_W-1:0] pool_hash [POOL_N];

    int  reqs_queued  = 0;
    int  rsps_checked = 0;
    int  err_count    = 0;
    int  idle_cycles  = 0;
    int  src_gap;
    int  sink_gap;
    int  hold_left;
    bit  sink_rdy;
    bit  calm      = 1'b0;
    bit  hold_go   = 1'b0;
    bit  hold_seen;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(0, 2);
    endfunction

    function automatic t_map_rsp map_update(t_map_req rq);
        t_map_rsp    rs;
        t_probe_res  outcome;
        int unsigned idx;
        int unsigned at;
        int unsigned tomb_at;
        bit          have_tomb;
        bit          room;
        int          n;
        rs        = '{status: oaht_pkg::ST_NOT_FOUND, was_new_key: 1'b0, value_out: '0};
        outcome   = PROBE_NONE;
        at        = 0;
        tomb_at   = 0;
        have_tomb = 1'b0;
        if (rq.req_type == REQ_UNUSED)
            return rs;
        idx = rq.key_hash % NSLOT;
        for (n = 0; n < NSLOT && outcome == PROBE_NONE; n++) begin
            if (tbl_kind[idx] == oaht_pkg::KIND_LIVE) begin
                if (tbl_key[idx] == rq.key_id) begin
                    outcome = PROBE_HIT;
                    at      = idx;
                end
            end else if (tbl_kind[idx] == oaht_pkg::KIND_TOMB) begin
                if (!have_tomb) begin
                    have_tomb = 1'b1;
                    tomb_at   = idx;
                end
            end else begin
                outcome = PROBE_EMPTY;
                at      = idx;
            end
            idx = (idx + 1) % NSLOT;
        end
        if (outcome != PROBE_HIT && have_tomb) begin
            outcome = PROBE_TOMB;
            at      = tomb_at;
        end
        room = (int'(tbl_count) + 1 <= int'(tbl_limit));
        case (rq.req_type)
            oaht_pkg::REQ_SET: begin
                if (outcome == PROBE_HIT) begin
                    tbl_val[at] = rq.new_value;
                    rs.status   = oaht_pkg::ST_OK;
                end else if (outcome == PROBE_TOMB || (outcome == PROBE_EMPTY && room)) begin
                    if (outcome == PROBE_EMPTY)
                        tbl_count = tbl_count + 1'b1;
                    tbl_kind[at]   = oaht_pkg::KIND_LIVE;
                    tbl_key[at]    = rq.key_id;
                    tbl_val[at]    = rq.new_value;
                    rs.status      = oaht_pkg::ST_OK;
                    rs.was_new_key = 1'b1;
                end else begin
                    rs.status = oaht_pkg::ST_FULL;
                end
            end
            oaht_pkg::REQ_GET: begin
                if (outcome == PROBE_HIT) begin
                    rs.status    = oaht_pkg::ST_OK;
                    rs.value_out = tbl_val[at];
                end
            end
            oaht_pkg::REQ_DEL: begin
                if (outcome == PROBE_HIT) begin
                    tbl_kind[at] = oaht_pkg::KIND_TOMB;
                    rs.status    = oaht_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        return rs;
    endfunction

    task automatic report_mismatch(input string what, input logic [oaht_pkg::VAL_W-1:0] got,
                                   input logic [oaht_pkg::VAL_W-1:0] want);
        err_count++;
        $display("mismatch at response %0d: %s got 0x%0h, expected 0x%0h",
                 rsps_checked, what, got, want);
    endtask

    task automatic queue_req(input logic [oaht_pkg::TYPE_W-1:0] kind,
                             input logic [oaht_pkg::KEY_W-1:0] key,
                             input logic [oaht_pkg::HASH_W-1:0] hash,
                             input logic [oaht_pkg::VAL_W-1:0] val);
        pending_reqs.push_back('{req_type: kind, key_id: key, key_hash: hash, new_value: val});
        reqs_queued++;
    endtask

    task automatic new_pool();
        logic [7:0]                  base [8];
        logic [oaht_pkg::HASH_W-1:0] h;
        int                          i;
        for (i = 0; i < 8; i++)
            base[i] = 8'($urandom_range(0, NSLOT - 1));
        // one cluster sits at the top of the table so probes wrap
        base[0] = 8'(NSLOT - 4);
        for (i = 0; i < POOL_N; i++) begin
            h            = $urandom();
            h[7:0]       = base[i % 8] + 8'($urandom_range(0, 5));
            pool_hash[i] = h;
            pool_key[i]  = $urandom();
        end
    endtask

    task automatic queue_pool_req();
        logic [oaht_pkg::VAL_W-1:0]  val;
        logic [oaht_pkg::TYPE_W-1:0] kind;
        int                          r;
        int                          j;
        val = {$urandom(), $urandom()};
        if ($urandom_range(0, 15) == 0)
            val = $urandom_range(0, 1) ? '1 : '0;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            queue_req(oaht_pkg::TYPE_W'($urandom_range(0, 3)), $urandom(), $urandom(), val);
        end else begin
            j = $urandom_range(0, POOL_N - 1);
            r = $urandom_range(0, 99);
            if (r < 45)
                kind = oaht_pkg::REQ_SET;
            else if (r < 75)
                kind = oaht_pkg::REQ_GET;
            else if (r < 95)
                kind = oaht_pkg::REQ_DEL;
            else
                kind = REQ_UNUSED;
            queue_req(kind, pool_key[j], pool_hash[j], val);
        end
    endtask

    task automatic wait_drained();
        while (rsps_checked != reqs_queued)
            @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [oaht_pkg::CFG_W-1:0] v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        tbl_limit = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int i;
        for (i = 0; i < count; i++)
            queue_pool_req();
        wait_drained();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid     <= 1'b0;
            req_if.req_type  <= '0;
            req_if.key_id    <= '0;
            req_if.key_hash  <= '0;
            req_if.new_value <= '0;
            src_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready)
                expected_rsps.push_back(map_update(cur_req));
            if (!req_if.valid || req_if.ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.req_type  <= cur_req.req_type;
                    req_if.key_id    <= cur_req.key_id;
                    req_if.key_hash  <= cur_req.key_hash;
                    req_if.new_value <= cur_req.new_value;
                    src_gap = calm ? 0 : pick_gap();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_go != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_go;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got_rsp = '{status: rsp_if.status, was_new_key: rsp_if.was_new_key,
                            value_out: rsp_if.value_out};
                if (expected_rsps.size() == 0) begin
                    report_mismatch("response with nothing pending", got_rsp.value_out, '0);
                end else begin
                    want_rsp = expected_rsps.pop_front();
                    if (got_rsp.status !== want_rsp.status)
                        report_mismatch("status", got_rsp.status, want_rsp.status);
                    if (got_rsp.was_new_key !== want_rsp.was_new_key)
                        report_mismatch("was_new_key", got_rsp.was_new_key,
                                        want_rsp.was_new_key);
                    if (got_rsp.value_out !== want_rsp.value_out)
                        report_mismatch("value_out", got_rsp.value_out, want_rsp.value_out);
                end
                rsps_checked++;
            end
            if (sink_gap != 0) begin
                sink_gap--;
                sink_rdy = 1'b0;
            end else begin
                sink_rdy = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    sink_gap = pick_gap();
            end
            rsp_if.ready <= sink_rdy && (hold_left == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                          i;
        int                          rr;
        int                          batches;
        int                          mark;
        logic [oaht_pkg::KEY_W-1:0]  k;
        logic [oaht_pkg::HASH_W-1:0] h;

        i_rst_n   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        for (i = 0; i < NSLOT; i++) begin
            tbl_kind[i] = oaht_pkg::KIND_EMPTY;
            tbl_key[i]  = '0;
            tbl_val[i]  = '0;
        end
        tbl_count = '0;
        tbl_limit = oaht_pkg::CFG_MAX_RST;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests at the reset load limit
        queue_req(oaht_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000, '0);
        queue_req(oaht_pkg::REQ_SET, 32'h0000_0000, 32'h0000_0000, '0);
        queue_req(oaht_pkg::REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        queue_req(oaht_pkg::REQ_SET, 32'h0000_0100, 32'hFFFF_FF00, 64'h0123_4567_89AB_CDEF);
        queue_req(oaht_pkg::REQ_SET, 32'h1234_5678, 32'h0000_00FF, 64'hFEDC_BA98_7654_3210);
        queue_req(oaht_pkg::REQ_GET, 32'h1234_5678, 32'h0000_00FF, '1);
        queue_req(oaht_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000, '1);
        queue_req(oaht_pkg::REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        queue_req(oaht_pkg::REQ_SET, 32'h0000_0000, 32'h0000_0000, 64'h5);
        queue_req(oaht_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000, '0);
        queue_req(oaht_pkg::REQ_DEL, 32'h0000_0000, 32'h0000_0000, '0);
        queue_req(oaht_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000, '0);
        queue_req(oaht_pkg::REQ_GET, 32'h1234_5678, 32'h0000_00FF, '0);
        queue_req(oaht_pkg::REQ_DEL, 32'h0000_0000, 32'h0000_0000, '0);
        queue_req(oaht_pkg::REQ_SET, 32'hA5A5_5A5A, 32'h0000_0000, 64'hAAAA_5555_AAAA_5555);
        queue_req(oaht_pkg::REQ_SET, 32'h0000_0000, 32'h0000_0000, 64'h5555_AAAA_5555_AAAA);
        queue_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        queue_req(oaht_pkg::REQ_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        queue_req(oaht_pkg::REQ_DEL, 32'h1234_5678, 32'h0000_00FF, '0);
        queue_req(oaht_pkg::REQ_SET, 32'h1234_5678, 32'h0000_00FF, 64'h1);
        queue_req(oaht_pkg::REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        queue_req(oaht_pkg::REQ_GET, 32'h1234_5678, 32'h0000_00FF, '0);
        queue_req(REQ_UNUSED, '0, '0, '0);
        queue_req(oaht_pkg::REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF, '0);
        wait_drained();

        // tight load limit, no idling
        @(posedge i_clk);
        calm <= 1'b1;
        set_limit(tbl_count + 9'd3);
        new_pool();
        run_random(150);

        // moderate load with a long receiver hold-off
        @(posedge i_clk);
        calm <= 1'b0;
        set_limit(9'd160);
        new_pool();
        mark = rsps_checked;
        for (i = 0; i < 450; i++)
            queue_pool_req();
        while (rsps_checked < mark + 40)
            @(posedge i_clk);
        @(posedge i_clk);
        hold_go <= ~hold_go;
        wait_drained();

        // fill every slot at the top limit
        set_limit(9'(NSLOT));
        rr      = 0;
        batches = 0;
        while (tbl_count != 9'(NSLOT) && batches < 16) begin
            for (i = 0; i < 32; i++) begin
                k             = $urandom();
                h             = $urandom();
                pool_key[rr]  = k;
                pool_hash[rr] = h;
                rr            = (rr + 1) % POOL_N;
                queue_req(oaht_pkg::REQ_SET, k, h, {$urandom(), $urandom()});
            end
            wait_drained();
            batches++;
        end

        // full table: full laps, tombstone reuse, lowest limit
        set_limit(9'd1);
        run_random(200);

        set_limit(9'd200);
        run_random(200);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && expected_rsps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
